// File: hdl/nmg_pkg.sv
// ----------------------------------------------------------------------------
// nmg_pkg
// Shared types, constants and command codes of the neural-mass gating step.
// ----------------------------------------------------------------------------
`default_nettype none

package nmg_pkg;

  // default depth of the 2^-f interpolation table
  localparam int EXP_TABLE_ENTRIES_DEF = 256;

  // model constants in fixed point
  localparam logic signed [35:0] J_Q24     = 36'sd4377176;
  localparam logic signed [35:0] D_Q24     = 36'sd2583691;
  localparam logic signed [35:0] LOG2E_Q24 = 36'sd24204406;
  localparam logic signed [40:0] B_Q24     = 41'sd1811939328;
  localparam logic [63:0]        LN2_Q32   = 64'd2977044472;
  localparam logic [31:0]        INV_D_Q22 = 32'd27235740;
  localparam logic [31:0]        S_RESTART = 32'd2147484;
  localparam logic [31:0]        S_ONE     = 32'h8000_0000;
  localparam logic [31:0]        RATE_MAX  = 32'hFFFF_FFFF;
  localparam int                 DIV_STEPS = 32;

  // register reset values
  localparam logic [31:0] RST_WEIGHT   = 32'd16777216;
  localparam logic [31:0] RST_COUPLING = 32'd0;
  localparam logic [31:0] RST_BASELINE = 32'd5033165;
  localparam logic [30:0] RST_SIGMA    = 31'd0;
  localparam logic [31:0] RST_GAMMA    = 32'd275305;
  localparam logic [31:0] RST_DECAY    = 32'd4294967;
  localparam logic [31:0] RST_SQRT     = 32'd1358187913;

  typedef enum logic [2:0] {
    CFG_WEIGHT   = 3'd0,
    CFG_COUPLING = 3'd1,
    CFG_BASELINE = 3'd2,
    CFG_SIGMA    = 3'd3,
    CFG_GAMMA    = 3'd4,
    CFG_DECAY    = 3'd5,
    CFG_SQRT     = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_W_J,
    MUL_G_J,
    MUL_WJ_S,
    MUL_GJ_IN,
    MUL_M_D,
    MUL_Z_L2E,
    MUL_F_N,
    MUL_DIFF_FR,
    MUL_M_Q,
    MUL_GAM_R,
    MUL_GR_OM,
    MUL_DEC_S,
    MUL_NZ_SQ,
    MUL_NS_SIG
  } mul_op_t;

  typedef enum logic [4:0] {
    CAP_NONE,
    CAP_LOAD,
    CAP_WJ,
    CAP_GJ,
    CAP_XA,
    CAP_X,
    CAP_AXB,
    CAP_Z,
    CAP_V,
    CAP_IDX,
    CAP_HI,
    CAP_LO,
    CAP_P,
    CAP_Q,
    CAP_DIV,
    CAP_DSTEP,
    CAP_RQ,
    CAP_R_INV,
    CAP_R_ZERO,
    CAP_R_MAX,
    CAP_GR,
    CAP_T1,
    CAP_ACC,
    CAP_NS,
    CAP_FIN
  } cap_t;

  typedef struct packed {
    mul_op_t mul_op;
    cap_t    cap;
    logic    rom_lo;
  } nmg_cmd_t;

  typedef struct packed {
    logic near_zero;
    logic neg_big;
    logic pos_big;
    logic den_zero;
  } nmg_stat_t;

endpackage

`default_nettype wire

// File: hdl/nmg_ctrl.sv
// ----------------------------------------------------------------------------
// nmg_ctrl
// Sequencer of one Euler step: issues multiplier and capture commands.
// ----------------------------------------------------------------------------
`default_nettype none

module nmg_ctrl
  import nmg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      in_restart,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire nmg_stat_t stat,
  output nmg_cmd_t       cmd
);

  localparam int CW = $clog2(DIV_STEPS);

  typedef enum logic [30:0] {
    ST_IDLE = 31'h0000_0001,
    ST_WJ   = 31'h0000_0002,
    ST_GJ   = 31'h0000_0004,
    ST_WS   = 31'h0000_0008,
    ST_GI   = 31'h0000_0010,
    ST_X    = 31'h0000_0020,
    ST_AXB  = 31'h0000_0040,
    ST_MD   = 31'h0000_0080,
    ST_Z    = 31'h0000_0100,
    ST_DEC  = 31'h0000_0200,
    ST_V    = 31'h0000_0400,
    ST_FN   = 31'h0000_0800,
    ST_IDX  = 31'h0000_1000,
    ST_RHI  = 31'h0000_2000,
    ST_RLO  = 31'h0000_4000,
    ST_LO   = 31'h0000_8000,
    ST_DF   = 31'h0001_0000,
    ST_P    = 31'h0002_0000,
    ST_Q    = 31'h0004_0000,
    ST_QD   = 31'h0008_0000,
    ST_DL   = 31'h0010_0000,
    ST_DIV  = 31'h0020_0000,
    ST_RQ   = 31'h0040_0000,
    ST_GR   = 31'h0080_0000,
    ST_GRC  = 31'h0100_0000,
    ST_GO   = 31'h0200_0000,
    ST_DS   = 31'h0400_0000,
    ST_NZ   = 31'h0800_0000,
    ST_NSC  = 31'h1000_0000,
    ST_T3   = 31'h2000_0000,
    ST_FIN  = 31'h4000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '{mul_op: MUL_NONE, cap: CAP_NONE, rom_lo: 1'b0};
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.cap   = CAP_LOAD;
          state_nxt = in_restart ? ST_FIN : ST_WJ;
        end
      end
      ST_WJ: begin
        cmd.mul_op = MUL_W_J;
        state_nxt  = ST_GJ;
      end
      ST_GJ: begin
        cmd.mul_op = MUL_G_J;
        cmd.cap    = CAP_WJ;
        state_nxt  = ST_WS;
      end
      ST_WS: begin
        cmd.mul_op = MUL_WJ_S;
        cmd.cap    = CAP_GJ;
        state_nxt  = ST_GI;
      end
      ST_GI: begin
        cmd.mul_op = MUL_GJ_IN;
        cmd.cap    = CAP_XA;
        state_nxt  = ST_X;
      end
      ST_X: begin
        cmd.cap   = CAP_X;
        state_nxt = ST_AXB;
      end
      ST_AXB: begin
        cmd.cap   = CAP_AXB;
        state_nxt = ST_MD;
      end
      ST_MD: begin
        cmd.mul_op = MUL_M_D;
        state_nxt  = ST_Z;
      end
      ST_Z: begin
        cmd.cap   = CAP_Z;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        // rate shortcuts: near zero, deep negative, large positive
        if (stat.near_zero) begin
          cmd.cap   = CAP_R_INV;
          state_nxt = ST_GR;
        end else if (stat.neg_big) begin
          cmd.cap   = CAP_R_ZERO;
          state_nxt = ST_GR;
        end else if (stat.pos_big) begin
          cmd.cap   = CAP_R_MAX;
          state_nxt = ST_GR;
        end else begin
          cmd.mul_op = MUL_Z_L2E;
          state_nxt  = ST_V;
        end
      end
      ST_V: begin
        cmd.cap   = CAP_V;
        state_nxt = ST_FN;
      end
      ST_FN: begin
        cmd.mul_op = MUL_F_N;
        state_nxt  = ST_IDX;
      end
      ST_IDX: begin
        cmd.cap   = CAP_IDX;
        state_nxt = ST_RHI;
      end
      ST_RHI: begin
        state_nxt = ST_RLO;
      end
      ST_RLO: begin
        cmd.rom_lo = 1'b1;
        cmd.cap    = CAP_HI;
        state_nxt  = ST_LO;
      end
      ST_LO: begin
        cmd.cap   = CAP_LO;
        state_nxt = ST_DF;
      end
      ST_DF: begin
        cmd.mul_op = MUL_DIFF_FR;
        state_nxt  = ST_P;
      end
      ST_P: begin
        cmd.cap   = CAP_P;
        state_nxt = ST_Q;
      end
      ST_Q: begin
        cmd.cap   = CAP_Q;
        state_nxt = ST_QD;
      end
      ST_QD: begin
        if (stat.den_zero) begin
          cmd.cap   = CAP_R_INV;
          state_nxt = ST_GR;
        end else begin
          cmd.mul_op = MUL_M_Q;
          state_nxt  = ST_DL;
        end
      end
      ST_DL: begin
        cmd.cap   = CAP_DIV;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.cap = CAP_DSTEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          state_nxt = ST_RQ;
        end
      end
      ST_RQ: begin
        cmd.cap   = CAP_RQ;
        state_nxt = ST_GR;
      end
      ST_GR: begin
        cmd.mul_op = MUL_GAM_R;
        state_nxt  = ST_GRC;
      end
      ST_GRC: begin
        cmd.cap   = CAP_GR;
        state_nxt = ST_GO;
      end
      ST_GO: begin
        cmd.mul_op = MUL_GR_OM;
        state_nxt  = ST_DS;
      end
      ST_DS: begin
        cmd.mul_op = MUL_DEC_S;
        cmd.cap    = CAP_T1;
        state_nxt  = ST_NZ;
      end
      ST_NZ: begin
        cmd.mul_op = MUL_NZ_SQ;
        cmd.cap    = CAP_ACC;
        state_nxt  = ST_NSC;
      end
      ST_NSC: begin
        cmd.cap   = CAP_NS;
        state_nxt = ST_T3;
      end
      ST_T3: begin
        cmd.mul_op = MUL_NS_SIG;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.cap       = CAP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/nmg_dp.sv
// ----------------------------------------------------------------------------
// nmg_dp
// Datapath: registers, shared multiplier, 2^-f table, bit-serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module nmg_dp
  import nmg_pkg::*;
#(
  parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_restart,
  input  wire logic signed [31:0] in_network_input,
  input  wire logic signed [15:0] in_noise_sample,
  input  wire nmg_cmd_t           cmd,
  output nmg_stat_t               stat,
  output logic signed [31:0]      out_input_current,
  output logic [31:0]             out_firing_rate,
  output logic [31:0]             out_gating
);

  localparam int AW = $clog2(EXP_TABLE_ENTRIES + 1);

  typedef logic [EXP_TABLE_ENTRIES:0][32:0] rom_t;

  // 2^(-i/N) in Q1.32 by a 25-term series
  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    for (int i = 0; i <= EXP_TABLE_ENTRIES; i++) begin
      t    = (LN2_Q32 * 64'(i)) / 64'(EXP_TABLE_ENTRIES);
      term = 64'h1_0000_0000;
      pos  = term;
      neg  = '0;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * t) >> 32) / 64'(k);
        if (k[0]) neg = neg + term;
        else pos = pos + term;
      end
      tab[i] = (pos > neg) ? 33'(pos - neg) : '0;
    end
    return tab;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  // configuration
  logic signed [31:0] w_r, g_r, i0_r;
  logic [30:0]        sigma_r;
  logic [31:0]        gamma_r, decay_r, sqrt_r;
  // state and inputs
  logic [31:0]        s_r;
  logic               restart_r;
  logic signed [31:0] netin_r;
  logic signed [15:0] noise_r;
  // working registers
  logic signed [71:0] prod_r;
  logic signed [30:0] wj_r, gj_r, xacc_r;
  logic signed [31:0] x_r;
  logic [39:0]        m_r;
  logic               neg_r;
  logic [31:0]        z_r;
  logic               near_zero_r;
  logic               n_big_r;
  logic [5:0]         n_sh_r;
  logic [23:0]        f_r, fr_r;
  logic [AW-1:0]      idx_r;
  logic [32:0]        rom_q_r, hi_r, diff_r, p_r, q_r, den_r;
  logic [34:0]        rem_r, dvs_r;
  logic [31:0]        dq_r;
  logic               ovf_r;
  logic [31:0]        r_r, gr_r;
  logic [41:0]        t1_r;
  logic signed [43:0] acc_r;
  logic signed [32:0] ns_r;

  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] rnd15, rnd20, rnd21, rnd23, rnd30, rnd31;
  logic [AW-1:0]      rom_addr;
  logic signed [39:0] xsum;
  logic signed [31:0] xsat;
  logic signed [40:0] x41, axb;
  logic [32:0]        qs, qc;
  logic [63:0]        dvd;
  logic [34:0]        dvs;
  logic [35:0]        dtry;
  logic               dge;
  logic [31:0]        om;
  logic [31:0]        t2;
  logic signed [42:0] t3;
  logic signed [45:0] sn;
  logic [31:0]        sclip;

  assign stat.near_zero = near_zero_r;
  assign stat.neg_big   = neg_r && (|m_r[39:32]);
  assign stat.pos_big   = !neg_r && (|m_r[39:34]);
  assign stat.den_zero  = (den_r == '0);

  assign om = S_ONE - s_r;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_op)
      MUL_W_J:     begin mul_a = 36'(w_r);                mul_b = J_Q24; end
      MUL_G_J:     begin mul_a = 36'(g_r);                mul_b = J_Q24; end
      MUL_WJ_S:    begin mul_a = 36'(wj_r);               mul_b = $signed({4'b0, s_r}); end
      MUL_GJ_IN:   begin mul_a = 36'(gj_r);               mul_b = 36'(netin_r); end
      MUL_M_D:     begin mul_a = $signed({2'b0, m_r[33:0]}); mul_b = D_Q24; end
      MUL_Z_L2E:   begin mul_a = $signed({4'b0, z_r});    mul_b = LOG2E_Q24; end
      MUL_F_N:     begin
        mul_a = $signed({12'b0, f_r});
        mul_b = 36'(EXP_TABLE_ENTRIES);
      end
      MUL_DIFF_FR: begin mul_a = $signed({3'b0, diff_r}); mul_b = $signed({12'b0, fr_r}); end
      MUL_M_Q:     begin mul_a = $signed({2'b0, m_r[33:0]}); mul_b = $signed({3'b0, q_r}); end
      MUL_GAM_R:   begin mul_a = $signed({4'b0, gamma_r}); mul_b = $signed({4'b0, r_r}); end
      MUL_GR_OM:   begin mul_a = $signed({4'b0, gr_r});   mul_b = $signed({4'b0, om}); end
      MUL_DEC_S:   begin mul_a = $signed({4'b0, decay_r}); mul_b = $signed({4'b0, s_r}); end
      MUL_NZ_SQ:   begin mul_a = 36'(noise_r);            mul_b = $signed({4'b0, sqrt_r}); end
      MUL_NS_SIG:  begin mul_a = 36'(ns_r);               mul_b = $signed({5'b0, sigma_r}); end
      default:     begin mul_a = '0;                      mul_b = '0; end
    endcase
  end

  // round-to-nearest offsets on the product
  assign rnd15 = prod_r + (72'sd1 <<< 15);
  assign rnd20 = prod_r + (72'sd1 <<< 20);
  assign rnd21 = prod_r + (72'sd1 <<< 21);
  assign rnd23 = prod_r + (72'sd1 <<< 23);
  assign rnd30 = prod_r + (72'sd1 <<< 30);
  assign rnd31 = prod_r + (72'sd1 <<< 31);

  // current sum and saturation
  assign xsum = 40'(xacc_r) + 40'($signed(rnd23[61:24])) + 40'(i0_r);
  always_comb begin
    if (xsum > 40'sd2147483647) xsat = 32'sh7FFF_FFFF;
    else if (xsum < -40'sd2147483648) xsat = 32'sh8000_0000;
    else xsat = xsum[31:0];
  end

  // axb = 270 x - 108
  assign x41 = 41'(x_r);
  assign axb = (x41 <<< 8) + (x41 <<< 3) + (x41 <<< 2) + (x41 <<< 1) - B_Q24;

  // exp shift by the integer part, then clamp to one
  assign qs = n_big_r ? 33'd0 : (p_r >> n_sh_r);
  assign qc = (qs > 33'h1_0000_0000) ? 33'h1_0000_0000 : qs;

  assign dvd = neg_r ? prod_r[63:0] : {m_r[33:0], 30'b0};
  assign dvs = neg_r ? {den_r, 2'b0} : {2'b0, den_r};

  assign dtry = {rem_r, dq_r[31]};
  assign dge  = (dtry >= {1'b0, dvs_r});

  assign t2 = rnd31[63:32];
  assign t3 = $signed(rnd20[63:21]);
  assign sn = 46'(acc_r) + 46'(t3);
  always_comb begin
    if (sn < 46'sd0) sclip = '0;
    else if (sn > 46'sd2147483648) sclip = S_ONE;
    else sclip = sn[31:0];
  end

  assign rom_addr = cmd.rom_lo ? idx_r + 1'b1 : idx_r;

  // configuration and gating state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= RST_WEIGHT;
      g_r     <= RST_COUPLING;
      i0_r    <= RST_BASELINE;
      sigma_r <= RST_SIGMA;
      gamma_r <= RST_GAMMA;
      decay_r <= RST_DECAY;
      sqrt_r  <= RST_SQRT;
      s_r     <= S_RESTART;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_WEIGHT:   w_r     <= cfg_wdata;
          CFG_COUPLING: g_r     <= cfg_wdata;
          CFG_BASELINE: i0_r    <= cfg_wdata;
          CFG_SIGMA:    sigma_r <= cfg_wdata[30:0];
          CFG_GAMMA:    gamma_r <= cfg_wdata;
          CFG_DECAY:    decay_r <= cfg_wdata;
          CFG_SQRT:     sqrt_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.cap == CAP_FIN) begin
        s_r <= restart_r ? S_RESTART : sclip;
      end
    end
  end

  // table read port
  always_ff @(posedge clk) begin
    rom_q_r <= EXP_ROM[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_op != MUL_NONE) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // payload captures
  always_ff @(posedge clk) begin
    case (cmd.cap)
      CAP_LOAD: begin
        restart_r <= in_restart;
        netin_r   <= in_network_input;
        noise_r   <= in_noise_sample;
      end
      CAP_WJ:  wj_r   <= $signed(rnd23[54:24]);
      CAP_GJ:  gj_r   <= $signed(rnd23[54:24]);
      CAP_XA:  xacc_r <= $signed(rnd30[61:31]);
      CAP_X:   x_r    <= xsat;
      CAP_AXB: begin
        neg_r <= axb[40];
        m_r   <= axb[40] ? 40'(-axb) : 40'(axb);
      end
      CAP_Z: begin
        z_r         <= rnd23[55:24];
        near_zero_r <= !(|m_r[39:34]) && !(|rnd23[55:32]);
      end
      CAP_V: begin
        n_big_r <= |rnd23[57:54];
        n_sh_r  <= rnd23[53:48];
        f_r     <= rnd23[47:24];
      end
      CAP_IDX: begin
        idx_r <= prod_r[24+AW-1:24];
        fr_r  <= prod_r[23:0];
      end
      CAP_HI:  hi_r   <= rom_q_r;
      CAP_LO:  diff_r <= (hi_r >= rom_q_r) ? hi_r - rom_q_r : '0;
      CAP_P:   p_r    <= hi_r - rnd23[56:24];
      CAP_Q: begin
        q_r   <= qc;
        den_r <= 33'h1_0000_0000 - qc;
      end
      CAP_DIV: begin
        // quotient beyond 32 bits is detected up front
        rem_r <= {3'b0, dvd[63:32]};
        dq_r  <= dvd[31:0];
        dvs_r <= dvs;
        ovf_r <= ({3'b0, dvd[63:32]} >= dvs);
      end
      CAP_DSTEP: begin
        rem_r <= dge ? 35'(dtry - {1'b0, dvs_r}) : dtry[34:0];
        dq_r  <= {dq_r[30:0], dge};
      end
      CAP_RQ:     r_r <= ovf_r ? RATE_MAX : dq_r;
      CAP_R_INV:  r_r <= INV_D_Q22;
      CAP_R_ZERO: r_r <= '0;
      CAP_R_MAX:  r_r <= RATE_MAX;
      CAP_GR:     gr_r <= rnd31[63:32];
      CAP_T1:     t1_r <= rnd21[63:22];
      CAP_ACC: begin
        acc_r <= $signed({12'b0, s_r}) + $signed({2'b0, t1_r}) - $signed({12'b0, t2});
      end
      CAP_NS: ns_r <= $signed(rnd15[48:16]);
      CAP_FIN: begin
        if (restart_r) begin
          out_input_current <= '0;
          out_firing_rate   <= '0;
          out_gating        <= S_RESTART;
        end else begin
          out_input_current <= x_r;
          out_firing_rate   <= r_r;
          out_gating        <= sclip;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/neural_mass_gating_step.sv
// ----------------------------------------------------------------------------
// neural_mass_gating_step
// One Euler step of a reduced excitatory neural-mass region per request.
// ----------------------------------------------------------------------------
// Each input request carries restart, network input and a noise sample; the
// block returns the input current, the firing rate and the new gating level.
// The gating level S is kept inside and updated by every request.
// A full step runs its multiplies on one shared 36x36 multiplier with a
// registered read of two neighbouring table entries, a bit-serial divide for
// the rate at one quotient bit per cycle, then the gating update.
// Rate shortcuts (near-zero, deep negative, large positive) skip the table and
// the divide; a zero denominator after the table skips the divide; a restart
// request skips the computation and goes straight to its result.
// One request is in flight at a time; in_ready is high only between steps.
// The result sits in an output register; a new request can be accepted while
// it waits, but the next result is held back until out_ready frees the slot.
// Configuration is a write-only port; the user must write it only while no
// request is in flight; the block does not enforce when writes are taken.
// Reset loads default configuration and S = 0.001, with no output pending.
// ----------------------------------------------------------------------------
`default_nettype none

module neural_mass_gating_step
  import nmg_pkg::*;
#(
  parameter int EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_idx,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_restart,
  input  wire logic signed [31:0] in_network_input,
  input  wire logic signed [15:0] in_noise_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_input_current,
  output logic [31:0]             out_firing_rate,
  output logic [31:0]             out_gating
);

  nmg_cmd_t  cmd;
  nmg_stat_t stat;

  nmg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  nmg_dp #(
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_restart        (in_restart),
    .in_network_input  (in_network_input),
    .in_noise_sample   (in_noise_sample),
    .cmd               (cmd),
    .stat              (stat),
    .out_input_current (out_input_current),
    .out_firing_rate   (out_firing_rate),
    .out_gating        (out_gating)
  );

  // result is only written into a free output slot
  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cap == CAP_FIN) |-> (!out_valid || out_ready))
    else $error("result written over a pending output");

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cap == CAP_FIN) |=> out_valid)
    else $error("finished step not presented");

  a_gating_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gating <= S_ONE))
    else $error("gating outside 0..1");

  a_idle_no_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cmd.mul_op == MUL_NONE))
    else $error("multiplier busy while accepting requests");

endmodule

`default_nettype wire
